// File: hw/rtl/lcdws_pkg.sv
`timescale 1ns / 1ps
// Shared types, command codes and the fixed strobe sequences of the
// character-LCD write sequencer. No dependencies.
package lcdws_pkg;

   localparam int MAX_DIGITS_DEF = 10;
   localparam int MAG_W          = 32;

   // Request kinds.
   localparam logic [2:0] KIND_INIT   = 3'd0;
   localparam logic [2:0] KIND_CMD    = 3'd1;
   localparam logic [2:0] KIND_DATA   = 3'd2;
   localparam logic [2:0] KIND_CURSOR = 3'd3;
   localparam logic [2:0] KIND_GLYPH  = 3'd4;
   localparam logic [2:0] KIND_NUMBER = 3'd5;

   // Controller command bytes and nibbles.
   localparam logic [7:0] CMD_FUNC_8BIT  = 8'h38;
   localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
   localparam logic [7:0] CMD_CLEAR      = 8'h01;
   localparam logic [7:0] NIB_FUNC_4BIT  = 8'h02;
   localparam logic [7:0] NIB_FUNC_LINES = 8'h08;
   localparam logic [7:0] CMD_CGRAM      = 8'h40;
   localparam logic [7:0] CMD_DDRAM      = 8'h80;
   localparam logic [7:0] ASCII_ZERO     = 8'd48;
   localparam logic [7:0] ASCII_MINUS    = 8'h2D;
   localparam logic [5:0] INIT_WAIT_MS   = 6'd40;

   typedef struct packed {
      logic [2:0]         kind;
      logic [7:0]         byte_value;
      logic [5:0]         column;
      logic [1:0]         row;
      logic [2:0]         glyph_slot;
      logic [63:0]        glyph_rows;
      logic signed [31:0] number;
   } req_type;

   typedef struct packed {
      logic       select_data;
      logic [7:0] bus_value;
      logic [5:0] wait_before_ms;
      logic       last;
   } rsp_type;

   // One byte for the strobe stage; single marks a raw nibble that is
   // sent as one strobe even on the four-bit bus.
   typedef struct packed {
      logic       rs;
      logic [7:0] value;
      logic [5:0] wait_ms;
      logic       single;
      logic       last;
   } byte_item_type;

   typedef struct packed {
      logic start;
      logic shift_digit;
   } bcd_ctrl_type;

   function automatic byte_item_type mk_item(input logic rs, input logic [7:0] value,
                                             input logic last);
      byte_item_type it;
      it.rs      = rs;
      it.value   = value;
      it.wait_ms = 6'd0;
      it.single  = 1'b0;
      it.last    = last;
      return it;
   endfunction

   // Byte for a given step of the fixed-length request kinds.
   function automatic byte_item_type seq_item(input req_type req, input logic [3:0] step,
                                              input logic nibble_mode);
      byte_item_type it;
      logic [7:0]    cursor;
      cursor = CMD_DDRAM | {req.row, req.column};
      it     = mk_item(1'b0, CMD_CLEAR, 1'b1);
      unique case (req.kind)
         KIND_INIT: begin
            if (!nibble_mode) begin
               unique case (step)
                  4'd0: begin
                     it = mk_item(1'b0, CMD_FUNC_8BIT, 1'b0);
                     it.wait_ms = INIT_WAIT_MS;
                  end
                  4'd1:    it = mk_item(1'b0, CMD_DISPLAY_ON, 1'b0);
                  default: it = mk_item(1'b0, CMD_CLEAR, 1'b1);
               endcase
            end else begin
               unique case (step)
                  4'd0: begin
                     it = mk_item(1'b0, NIB_FUNC_4BIT, 1'b0);
                     it.wait_ms = INIT_WAIT_MS;
                     it.single  = 1'b1;
                  end
                  4'd1: begin
                     it = mk_item(1'b0, NIB_FUNC_4BIT, 1'b0);
                     it.single = 1'b1;
                  end
                  4'd2: begin
                     it = mk_item(1'b0, NIB_FUNC_LINES, 1'b0);
                     it.single = 1'b1;
                  end
                  4'd3:    it = mk_item(1'b0, CMD_DISPLAY_ON, 1'b0);
                  default: it = mk_item(1'b0, CMD_CLEAR, 1'b1);
               endcase
            end
         end
         KIND_CMD:    it = mk_item(1'b0, req.byte_value, 1'b1);
         KIND_DATA:   it = mk_item(1'b1, req.byte_value, 1'b1);
         KIND_CURSOR: it = mk_item(1'b0, cursor, 1'b1);
         KIND_GLYPH: begin
            unique case (step)
               4'd0:  it = mk_item(1'b0, CMD_CGRAM | {2'b00, req.glyph_slot, 3'b000}, 1'b0);
               4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8:
                  it = mk_item(1'b1, req.glyph_rows[8*(step-4'd1) +: 8], 1'b0);
               4'd9:    it = mk_item(1'b0, cursor, 1'b0);
               default: it = mk_item(1'b1, {5'd0, req.glyph_slot}, 1'b1);
            endcase
         end
         default: it = mk_item(1'b0, CMD_CLEAR, 1'b1);
      endcase
      return it;
   endfunction

endpackage

// File: hw/rtl/lcdws_bcd.sv
`timescale 1ns / 1ps
// Iterative binary to BCD converter (shift and add-3), one bit per cycle,
// with a digit shift for reading digits out from the top. Uses lcdws_pkg.
module lcdws_bcd import lcdws_pkg::*; #(
   parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  bcd_ctrl_type     ctrl,
   input  logic [MAG_W-1:0] mag_value,
   output logic             busy,
   output logic [3:0]       top_digit
);

   localparam int BCD_W = 4 * MAX_DIGITS;
   localparam int CNT_W = $clog2(MAG_W);

   logic [BCD_W-1:0] bcd_ff, bcd_in, adj;
   logic [MAG_W-1:0] bin_ff, bin_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;

   // Every digit of five or more gets three added before the shift.
   always_comb begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
         adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                    : bcd_ff[4*i +: 4];
      end
   end

   always_comb begin
      bcd_in  = bcd_ff;
      bin_in  = bin_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (ctrl.start) begin
         bcd_in  = '0;
         bin_in  = mag_value;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bcd_in = {adj[BCD_W-2:0], bin_ff[MAG_W-1]};
         bin_in = {bin_ff[MAG_W-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(MAG_W - 1)) begin
            busy_in = 1'b0;
         end
      end else if (ctrl.shift_digit) begin
         bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      bcd_ff <= bcd_in;
      bin_ff <= bin_in;
      cnt_ff <= cnt_in;
   end

   assign busy      = busy_ff;
   assign top_digit = bcd_ff[BCD_W-1 -: 4];

endmodule

// File: hw/rtl/lcdws_emit.sv
`timescale 1ns / 1ps
// Strobe stage: turns bytes into strobes (two nibbles on the four-bit bus)
// and holds the result register toward the receiver. Uses lcdws_pkg.
module lcdws_emit import lcdws_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          nibble_mode,
   input  logic          byte_valid,
   input  byte_item_type byte_item,
   output logic          byte_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data
);

   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;
   logic    low_pend_ff, low_pend_in;
   rsp_type low_ff, low_in;
   logic    split;

   assign byte_ready = !low_pend_ff && (!out_valid_ff || rsp_ready);
   assign split      = nibble_mode && !byte_item.single;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      low_pend_in  = low_pend_ff;
      low_in       = low_ff;
      if (out_valid_ff && rsp_ready) begin
         if (low_pend_ff) begin
            out_in      = low_ff;
            low_pend_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
      if (byte_valid && byte_ready) begin
         out_valid_in = 1'b1;
         if (split) begin
            // High nibble goes first; the low nibble carries the last flag.
            out_in      = '{byte_item.rs, {4'd0, byte_item.value[7:4]}, byte_item.wait_ms, 1'b0};
            low_in      = '{byte_item.rs, {4'd0, byte_item.value[3:0]}, 6'd0, byte_item.last};
            low_pend_in = 1'b1;
         end else begin
            out_in = '{byte_item.rs, byte_item.value, byte_item.wait_ms, byte_item.last};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         low_pend_ff  <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         low_pend_ff  <= low_pend_in;
      end
      out_ff <= out_in;
      low_ff <= low_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTHESIS
   a_low_needs_high: assert property (@(posedge clock) disable iff (reset)
      low_pend_ff |-> out_valid_ff)
      else $error("low nibble pending without a high nibble in the output register");
   a_split_pends: assert property (@(posedge clock) disable iff (reset)
      (byte_valid && byte_ready && split) |=> (low_pend_ff && out_valid_ff))
      else $error("split byte did not leave its low nibble pending");
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result changed while the receiver stalled");
`endif

endmodule

// File: hw/rtl/char_lcd_write_sequencer_top.sv
`timescale 1ns / 1ps
// Character-LCD write sequencer: request expansion sequencer, BCD unit and
// strobe stage. Uses lcdws_pkg, lcdws_bcd and lcdws_emit.
//
// Usage: a request transfer on req_* (init, command, data, cursor move,
// glyph write or signed number) expands into a run of strobes, one result
// transfer on rsp_* each, with rsp_data.last set on the final one. Kinds
// six and seven are taken and produce nothing. csr_write_en writes the bus
// mode (bit 0: 1 selects the four-bit bus); write it only while idle.
// req_ready is high only while the sequencer is idle, so one request is in
// work at a time. Fixed requests hand one byte per cycle to the strobe stage
// while the receiver is ready and no low nibble is pending; the stage splits
// each byte not marked single into two strobes on the four-bit bus; at most
// 22 strobes. A request keeps req_ready low until its last byte is taken.
// A number is first converted in 32 shift-and-add steps of the BCD unit,
// then its digits are read out from the top, and leading zeros of its
// MAX_DIGITS digit positions are skipped and not sent. For fixed kinds the
// first byte is offered from the sequencing state. A stalled receiver
// holds the output register and the sequencer waits; nothing is lost.
// Synchronous reset returns to idle, output empty, eight-bit bus selected.
module char_lcd_write_sequencer_top import lcdws_pkg::*; #(
   parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_write_en,
   input  logic    csr_write_data
);

   localparam int DIG_W = $clog2(MAX_DIGITS);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SEQ   = 3'd1;
   localparam logic [2:0] S_CONV  = 3'd2;
   localparam logic [2:0] S_SIGN  = 3'd3;
   localparam logic [2:0] S_DIGIT = 3'd4;

   logic [2:0]       state_ff, state_in;
   req_type          req_ff, req_in;
   logic [3:0]       step_ff, step_in;
   logic [DIG_W-1:0] dig_ff, dig_in;
   logic             started_ff, started_in;
   logic             nibble_mode_ff;

   logic             req_take;
   logic             byte_valid, byte_ready;
   byte_item_type    byte_item;
   bcd_ctrl_type     bcd_ctrl;
   logic [MAG_W-1:0] mag_value;
   logic             bcd_busy;
   logic [3:0]       top_digit;
   logic             skip;

   assign req_ready = (state_ff == S_IDLE);
   assign req_take  = req_valid && req_ready;
   // Unsigned negate gives the true magnitude of the most negative value.
   assign mag_value = req_data.number[31] ? (MAG_W'(0) - MAG_W'(req_data.number))
                                          : MAG_W'(req_data.number);
   assign skip = !started_ff && (top_digit == 4'd0) && (dig_ff != '0);

   always_comb begin
      state_in   = state_ff;
      req_in     = req_ff;
      step_in    = step_ff;
      dig_in     = dig_ff;
      started_in = started_ff;
      byte_valid = 1'b0;
      byte_item  = seq_item(req_ff, step_ff, nibble_mode_ff);
      bcd_ctrl   = '{start: 1'b0, shift_digit: 1'b0};
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               req_in  = req_data;
               step_in = 4'd0;
               if (req_data.kind == KIND_NUMBER) begin
                  bcd_ctrl.start = 1'b1;
                  state_in       = S_CONV;
               end else if (req_data.kind == KIND_INIT || req_data.kind == KIND_CMD ||
                            req_data.kind == KIND_DATA || req_data.kind == KIND_CURSOR ||
                            req_data.kind == KIND_GLYPH) begin
                  state_in = S_SEQ;
               end
            end
         end
         S_SEQ: begin
            byte_valid = 1'b1;
            if (byte_ready) begin
               step_in = step_ff + 4'd1;
               if (byte_item.last) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_CONV: begin
            if (!bcd_busy) begin
               dig_in     = DIG_W'(MAX_DIGITS - 1);
               started_in = 1'b0;
               state_in   = req_ff.number[31] ? S_SIGN : S_DIGIT;
            end
         end
         S_SIGN: begin
            byte_valid = 1'b1;
            byte_item  = mk_item(1'b1, ASCII_MINUS, 1'b0);
            if (byte_ready) begin
               state_in = S_DIGIT;
            end
         end
         S_DIGIT: begin
            byte_item = mk_item(1'b1, ASCII_ZERO + {4'd0, top_digit}, dig_ff == '0);
            if (skip) begin
               bcd_ctrl.shift_digit = 1'b1;
               dig_in               = dig_ff - DIG_W'(1);
            end else begin
               byte_valid = 1'b1;
               if (byte_ready) begin
                  started_in = 1'b1;
                  if (dig_ff == '0) begin
                     state_in = S_IDLE;
                  end else begin
                     bcd_ctrl.shift_digit = 1'b1;
                     dig_in               = dig_ff - DIG_W'(1);
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         nibble_mode_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_en) begin
            nibble_mode_ff <= csr_write_data;
         end
      end
      req_ff     <= req_in;
      step_ff    <= step_in;
      dig_ff     <= dig_in;
      started_ff <= started_in;
   end

   lcdws_bcd #(
      .MAX_DIGITS(MAX_DIGITS)
   ) u_bcd (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (bcd_ctrl),
      .mag_value(mag_value),
      .busy     (bcd_busy),
      .top_digit(top_digit)
   );

   lcdws_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .nibble_mode(nibble_mode_ff),
      .byte_valid (byte_valid),
      .byte_item  (byte_item),
      .byte_ready (byte_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTHESIS
   a_idle_no_bytes: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !byte_valid)
      else $error("byte offered while the sequencer is idle");
   a_number_starts_bcd: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_data.kind == KIND_NUMBER) |=> (bcd_busy && state_ff == S_CONV))
      else $error("number request did not start the BCD unit");
   a_digits_after_conv: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SIGN || state_ff == S_DIGIT) |-> !bcd_busy)
      else $error("digit readout while the BCD unit is still converting");
`endif

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for char_lcd_write_sequencer_top: a strobe predictor
// fed by each request transfer, checked against every result transfer.
// Depends on lcdws_pkg and the sequencer RTL.
module tb_top import lcdws_pkg::*; ();

   localparam logic [2:0] KIND_SPARE_6 = 3'd6;
   localparam logic [2:0] KIND_SPARE_7 = 3'd7;
   localparam int         CYCLE_LIMIT  = 400000;
   localparam int         SETTLE_CYCLES = 120;
   localparam int         RANDOM_ITEMS = 80;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b1;
   rsp_type rsp_data;
   logic    csr_write_en = 1'b0;
   logic    csr_write_data = 1'b0;

   rsp_type pending_strobes[$];
   rsp_type run_strobes[$];
   logic    nibble_bus = 1'b0;
   int      send_idle_pct = 0;
   int      rsp_stall_pct = 0;
   int      fail_count = 0;
   int      cycle_count = 0;

   char_lcd_write_sequencer_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_write_en  (csr_write_en),
      .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= rsp_stall_pct);
   end

   // ---------------------------------------------------------------
   // Strobe predictor
   // ---------------------------------------------------------------
   task automatic add_strobe(input logic rs, input logic [7:0] val, input logic [5:0] wait_ms);
      rsp_type s;
      s.select_data    = rs;
      s.bus_value      = val;
      s.wait_before_ms = wait_ms;
      s.last           = 1'b0;
      run_strobes.push_back(s);
   endtask

   // On the four-bit bus a byte goes out as two nibbles, high one first.
   task automatic add_byte(input logic rs, input logic [7:0] val);
      if (!nibble_bus) begin
         add_strobe(rs, val, 6'd0);
      end else begin
         add_strobe(rs, {4'h0, val[7:4]}, 6'd0);
         add_strobe(rs, {4'h0, val[3:0]}, 6'd0);
      end
   endtask

   task automatic expand_request(input req_type r);
      logic [7:0]  cursor;
      logic [31:0] mag;
      logic [3:0]  digit_buf[MAX_DIGITS_DEF];
      int          count;
      run_strobes.delete();
      cursor = CMD_DDRAM | {r.row, r.column};
      count  = 0;
      case (r.kind)
         KIND_INIT: begin
            if (!nibble_bus) begin
               add_strobe(1'b0, CMD_FUNC_8BIT, INIT_WAIT_MS);
            end else begin
               add_strobe(1'b0, NIB_FUNC_4BIT, INIT_WAIT_MS);
               add_strobe(1'b0, NIB_FUNC_4BIT, 6'd0);
               add_strobe(1'b0, NIB_FUNC_LINES, 6'd0);
            end
            add_byte(1'b0, CMD_DISPLAY_ON);
            add_byte(1'b0, CMD_CLEAR);
         end
         KIND_CMD:    add_byte(1'b0, r.byte_value);
         KIND_DATA:   add_byte(1'b1, r.byte_value);
         KIND_CURSOR: add_byte(1'b0, cursor);
         KIND_GLYPH: begin
            add_byte(1'b0, CMD_CGRAM | {2'b00, r.glyph_slot, 3'b000});
            for (int k = 0; k < 8; k++) begin
               add_byte(1'b1, r.glyph_rows[8*k +: 8]);
            end
            add_byte(1'b0, cursor);
            add_byte(1'b1, {5'd0, r.glyph_slot});
         end
         KIND_NUMBER: begin
            // The magnitude is taken as unsigned, so the most negative
            // value prints all ten digits.
            if (r.number[31]) begin
               mag = 32'd0 - r.number;
               add_byte(1'b1, ASCII_MINUS);
            end else begin
               mag = r.number;
            end
            if (mag == 32'd0) begin
               add_byte(1'b1, ASCII_ZERO);
            end else begin
               while (mag != 32'd0 && count < MAX_DIGITS_DEF) begin
                  digit_buf[count] = 4'(mag % 32'd10);
                  mag = mag / 32'd10;
                  count++;
               end
               while (count > 0) begin
                  count--;
                  add_byte(1'b1, ASCII_ZERO + {4'd0, digit_buf[count]});
               end
            end
         end
         default: ;
      endcase
      if (run_strobes.size() > 0) begin
         run_strobes[run_strobes.size() - 1].last = 1'b1;
      end
      foreach (run_strobes[i]) begin
         pending_strobes.push_back(run_strobes[i]);
      end
   endtask

   // ---------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_strobes.size() == 0) begin
            $error("unexpected strobe transfer: rs %0d bus %0h", rsp_data.select_data,
                   rsp_data.bus_value);
            fail_count++;
         end else begin
            want = pending_strobes.pop_front();
            if (rsp_data.select_data !== want.select_data) begin
               $error("select_data: expected %0d, got %0d", want.select_data,
                      rsp_data.select_data);
               fail_count++;
            end
            if (rsp_data.bus_value !== want.bus_value) begin
               $error("bus_value: expected %0h, got %0h", want.bus_value, rsp_data.bus_value);
               fail_count++;
            end
            if (rsp_data.wait_before_ms !== want.wait_before_ms) begin
               $error("wait_before_ms: expected %0d, got %0d", want.wait_before_ms,
                      rsp_data.wait_before_ms);
               fail_count++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_data.last);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   task automatic send_item(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = r;
      do begin
         @(posedge clock);
      end while (!req_ready);
      expand_request(r);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_for_drain();
      while (pending_strobes.size() > 0) begin
         @(negedge clock);
      end
   endtask

   // A spare-kind request gives no strobe, so the block may still be busy
   // after the last strobe; the settle time covers the number path too.
   task automatic set_bus_mode(input logic nibble_mode);
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_en   = 1'b1;
      csr_write_data = nibble_mode;
      @(negedge clock);
      csr_write_en   = 1'b0;
      nibble_bus     = nibble_mode;
   endtask

   function automatic req_type blank_request(input logic [2:0] kind);
      req_type r;
      r      = '0;
      r.kind = kind;
      return r;
   endfunction

   function automatic req_type random_request();
      req_type r;
      r.kind       = ($urandom_range(99) < 4) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5, 0));
      r.byte_value = 8'($urandom);
      r.column     = 6'($urandom);
      r.row        = 2'($urandom);
      r.glyph_slot = 3'($urandom);
      r.glyph_rows = {$urandom, $urandom};
      case ($urandom_range(3))
         0:       r.number = $signed($urandom_range(200)) - 100;
         1:       r.number = ($urandom_range(1) == 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         default: r.number = $urandom;
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   // Runs before any register write, so it also covers the reset bus mode.
   task automatic test_eight_bit_after_reset();
      req_type r;
      send_item(blank_request(KIND_INIT));
      r = blank_request(KIND_CMD);
      send_item(r);
      r = blank_request(KIND_DATA);
      r.byte_value = 8'hFF;
      send_item(r);
      r = blank_request(KIND_CURSOR);
      r.row = 2'd3;
      r.column = 6'd63;
      send_item(r);
      send_item(blank_request(KIND_CURSOR));
      r = blank_request(KIND_GLYPH);
      r.glyph_slot = 3'd7;
      r.glyph_rows = '1;
      r.row = 2'd3;
      r.column = 6'd63;
      send_item(r);
      send_item(blank_request(KIND_GLYPH));
      send_item(blank_request(KIND_NUMBER));
      r = blank_request(KIND_NUMBER);
      r.number = -1;
      send_item(r);
      r.number = 32'sh8000_0000;
      send_item(r);
      r.number = 32'sh7FFF_FFFF;
      send_item(r);
      send_item(blank_request(KIND_SPARE_6));
      send_item(blank_request(KIND_SPARE_7));
   endtask

   task automatic test_four_bit_sequences();
      req_type r;
      set_bus_mode(1'b1);
      send_item(blank_request(KIND_INIT));
      r = blank_request(KIND_CMD);
      r.byte_value = 8'hA5;
      send_item(r);
      r = blank_request(KIND_DATA);
      r.byte_value = 8'h5A;
      send_item(r);
      r = blank_request(KIND_CURSOR);
      r.row = 2'd1;
      r.column = 6'd42;
      send_item(r);
      r = blank_request(KIND_GLYPH);
      r.glyph_slot = 3'd5;
      r.glyph_rows = 64'h0123_4567_89AB_CDEF;
      send_item(r);
      r = blank_request(KIND_NUMBER);
      r.number = 32'sh8000_0000;
      send_item(r);
      r.number = 7;
      send_item(r);
      send_item(blank_request(KIND_SPARE_7));
   endtask

   task automatic test_random_traffic(input logic nibble_mode, input int idle_pct,
                                      input int stall_pct);
      req_type r;
      int      sent;
      set_bus_mode(nibble_mode);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         r = random_request();
         send_item(r);
         if (r.kind <= KIND_NUMBER) begin
            sent++;
         end
      end
      send_idle_pct = 0;
      rsp_stall_pct = 0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_eight_bit_after_reset();
      test_four_bit_sequences();
      test_random_traffic(1'b1, 0, 0);
      test_random_traffic(1'b0, 53, 0);
      test_random_traffic(1'b1, 0, 53);
      test_random_traffic(1'b0, 21, 21);

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: char_lcd_write_sequencer_top.f
hw/rtl/lcdws_pkg.sv
hw/rtl/lcdws_bcd.sv
hw/rtl/lcdws_emit.sv
hw/rtl/char_lcd_write_sequencer_top.sv
tb/sv/tb_top.sv
